// File: hw/rtl/sdr_pkg.sv
`timescale 1ns / 1ps
package sdr_pkg;

  // Fixed-point vector width: sign, integer headroom and 16 fraction bits.
  localparam int VecW = 24;
  localparam int FracBits = 16;
  localparam int GainInvQ = 39797;
  localparam int AngW = 16;
  localparam int MaxSteps = 32;

  typedef logic [1:0] action_t;
  localparam action_t ActSet  = 2'd0;
  localparam action_t ActRotX = 2'd1;
  localparam action_t ActRotY = 2'd2;
  localparam action_t ActRotZ = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StRot1,
    StRot2,
    StRot3,
    StVec1,
    StVec2,
    StDone
  } sdr_state_t;

  // Datapath operation selected by the controller.
  typedef enum logic [2:0] {
    OpNone,
    OpLoad,
    OpRotPolar,
    OpRotAzim,
    OpRotAxis,
    OpVecAzim,
    OpVecPolar
  } sdr_op_t;

  typedef struct packed {
    logic    start;
    sdr_op_t op;
  } sdr_cmd_t;

  typedef struct packed {
    logic busy;
  } sdr_stat_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn32(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
      5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
      5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
      5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
      5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001; default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

// File: hw/rtl/sdr_if.sv
`timescale 1ns / 1ps
interface sdr_in_if;
  import sdr_pkg::*;
  logic        valid;
  logic        ready;
  action_t     action;
  logic [15:0] polar_in;
  logic [15:0] azim_in;
  logic [15:0] turn_angle;
  modport source (output valid, action, polar_in, azim_in, turn_angle, input ready);
  modport sink (input valid, action, polar_in, azim_in, turn_angle, output ready);
endinterface

interface sdr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] zenith_out;
  logic [15:0] azimuth_out;
  modport source (output valid, zenith_out, azimuth_out, input ready);
  modport sink (input valid, zenith_out, azimuth_out, output ready);
endinterface

// File: hw/rtl/sdr_ctrl.sv
`timescale 1ns / 1ps
module sdr_ctrl
  import sdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  action_t    in_action,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       load_out,
  output sdr_cmd_t   cmd,
  input  sdr_stat_t  stat
);

  sdr_state_t state_r, state_nxt;
  logic       started_r, started_nxt;
  logic       have_out_r, have_out_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= StIdle;
      started_r  <= 1'b0;
      have_out_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      started_r  <= started_nxt;
      have_out_r <= have_out_nxt;
    end
  end

  // Next state: each pass is started once and then waits for the datapath.
  always_comb begin
    state_nxt    = state_r;
    started_nxt  = started_r;
    have_out_nxt = have_out_r;
    if (have_out_r && out_ready) begin
      have_out_nxt = 1'b0;
    end
    case (state_r)
      StIdle: begin
        if (in_valid && in_ready) begin
          state_nxt   = (in_action == ActSet) ? StDone : StRot1;
          started_nxt = 1'b0;
        end
      end
      StRot1, StRot2, StRot3, StVec1, StVec2: begin
        if (!started_r) begin
          started_nxt = 1'b1;
        end else if (!stat.busy) begin
          started_nxt = 1'b0;
          case (state_r)
            StRot1:  state_nxt = StRot2;
            StRot2:  state_nxt = StRot3;
            StRot3:  state_nxt = StVec1;
            StVec1:  state_nxt = StVec2;
            default: state_nxt = StDone;
          endcase
        end
      end
      StDone: begin
        if (!have_out_r || out_ready) begin
          have_out_nxt = 1'b1;
          state_nxt    = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OpNone;
    load_out  = 1'b0;
    in_ready  = (state_r == StIdle);
    out_valid = have_out_r;
    case (state_r)
      StIdle: begin
        if (in_valid) cmd.op = OpLoad;
      end
      StRot1: begin cmd.op = OpRotPolar; cmd.start = !started_r; end
      StRot2: begin cmd.op = OpRotAzim;  cmd.start = !started_r; end
      StRot3: begin cmd.op = OpRotAxis;  cmd.start = !started_r; end
      StVec1: begin cmd.op = OpVecAzim;  cmd.start = !started_r; end
      StVec2: begin cmd.op = OpVecPolar; cmd.start = !started_r; end
      StDone: begin
        load_out = !have_out_r || out_ready;
      end
      default: cmd.op = OpNone;
    endcase
  end

  // A request is only taken when the controller is idle.
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == StIdle) else $error("ready outside idle");
  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // Start is never issued while the datapath is busy.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !stat.busy) else $error("start while busy");

endmodule

// File: hw/rtl/sdr_dp.sv
`timescale 1ns / 1ps
module sdr_dp
  import sdr_pkg::*;
#(
  parameter int CordicSteps = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sdr_cmd_t    cmd,
  output sdr_stat_t   stat,
  input  logic        in_fire,
  input  action_t     in_action,
  input  logic [15:0] in_polar,
  input  logic [15:0] in_azim,
  input  logic [15:0] in_turn,
  output logic [15:0] zenith,
  output logic [15:0] azimuth
);

  localparam int CntW = $clog2(CordicSteps + 1);
  localparam logic [15:0] Half = 16'h8000;
  localparam logic signed [17:0] HalfS = 18'sd32768;
  localparam logic signed [17:0] QuarterS = 18'sd16384;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [17:0] ang_t;

  logic [15:0] zen_r, az_r;
  action_t     act_r;
  logic [15:0] turn_r;
  vec_t        vx_r, vy_r, vz_r, vrad_r;
  vec_t        cx_r, cy_r, cx_nxt, cy_nxt;
  ang_t        ca_r, ca_nxt;
  logic        busy_r;
  logic        mode_vec_r;
  logic [CntW-1:0] cnt_r;
  sdr_op_t     op_r;

  logic [15:0] theta_f;
  ang_t        atan_i;
  vec_t        sx, sy;
  logic [15:0] rot_ang;
  ang_t        za;
  vec_t        ga, gb;
  vec_t        gx, gy;
  logic signed [VecW+16:0] gxp, gyp;
  ang_t        th_c;

  assign stat.busy = busy_r;
  assign zenith    = zen_r;
  assign azimuth   = az_r;

  // Set-direction fold of the polar angle.
  always_comb begin
    theta_f = in_polar;
    if (in_polar > Half) theta_f = 16'(17'h10000 - {1'b0, in_polar});
  end

  // Rounded arctangent of the current step, in turn units.
  always_comb begin
    logic [31:0] t;
    logic [4:0]  i5;
    i5 = 5'(cnt_r);
    t = atan_turn32(i5);
    atan_i = ang_t'((t + 32'h8000) >> 16);
  end

  // Operand selection for the pass being started.
  always_comb begin
    ga = '0; gb = '0; rot_ang = '0;
    case (cmd.op)
      OpRotPolar: begin ga = vec_t'(1 <<< FracBits); gb = '0; rot_ang = Half - zen_r; end
      OpRotAzim:  begin ga = vy_r; gb = '0; rot_ang = az_r - Half; end
      OpRotAxis: begin
        rot_ang = turn_r;
        case (act_r)
          ActRotX: begin ga = vy_r; gb = vz_r; end
          ActRotY: begin ga = vz_r; gb = vx_r; end
          default: begin ga = vx_r; gb = vy_r; end
        endcase
      end
      OpVecAzim:  begin ga = vx_r; gb = vy_r; end
      OpVecPolar: begin ga = vz_r; gb = vrad_r; end
      default: begin ga = '0; gb = '0; end
    endcase
  end

  // Gain multiply used at rotation start and after vectoring.
  always_comb begin
    vec_t ma, mb;
    ma = (busy_r) ? cx_r : ga;
    mb = gb;
    gxp = ma * (VecW+17)'(signed'(GainInvQ));
    gyp = mb * (VecW+17)'(signed'(GainInvQ));
    gx = vec_t'(gxp >>> FracBits);
    gy = vec_t'(gyp >>> FracBits);
  end

  // Rotation start: range reduction into the quarter turn.
  always_comb begin
    za = ang_t'(signed'({2'b00, rot_ang}));
    if (za >= HalfS) za = za - (HalfS + HalfS);
  end

  // One CORDIC iteration per cycle.
  always_comb begin
    cx_nxt = cx_r; cy_nxt = cy_r; ca_nxt = ca_r;
    sx = cx_r >>> cnt_r;
    sy = cy_r >>> cnt_r;
    if (mode_vec_r ? (cy_r >= 0) : (ca_r >= 0)) begin
      if (mode_vec_r) begin
        cx_nxt = cx_r + sy; cy_nxt = cy_r - sx; ca_nxt = ca_r + atan_i;
      end else begin
        cx_nxt = cx_r - sy; cy_nxt = cy_r + sx; ca_nxt = ca_r - atan_i;
      end
    end else begin
      if (mode_vec_r) begin
        cx_nxt = cx_r - sy; cy_nxt = cy_r + sx; ca_nxt = ca_r - atan_i;
      end else begin
        cx_nxt = cx_r + sy; cy_nxt = cy_r - sx; ca_nxt = ca_r + atan_i;
      end
    end
  end

  // Clamped polar result from the final vectoring pass.
  always_comb begin
    th_c = ca_r;
    if (th_c < 0) th_c = '0;
    if (th_c > HalfS) th_c = HalfS;
  end

  // Request capture, pass start and control of the iteration counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      zen_r  <= '0;
      az_r   <= '0;
      op_r   <= OpNone;
    end else begin
      if (in_fire) begin
        act_r  <= in_action;
        turn_r <= in_turn;
        if (in_action == ActSet) begin
          zen_r <= Half - theta_f;
          az_r  <= in_azim + Half;
        end
      end
      if (cmd.start) begin
        op_r <= cmd.op;
        cnt_r <= '0;
        if (cmd.op == OpVecAzim || cmd.op == OpVecPolar) begin
          mode_vec_r <= 1'b1;
          busy_r <= !(ga == 0 && gb == 0);
          if (ga == 0 && gb == 0) begin
            cx_r <= '0; cy_r <= '0; ca_r <= '0;
          end else if (ga < 0) begin
            cx_r <= -ga; cy_r <= -gb; ca_r <= HalfS;
          end else begin
            cx_r <= ga; cy_r <= gb; ca_r <= '0;
          end
        end else begin
          mode_vec_r <= 1'b0;
          busy_r <= 1'b1;
          if (za > QuarterS) begin
            cx_r <= -gx; cy_r <= -gy; ca_r <= za - HalfS;
          end else if (za < -QuarterS) begin
            cx_r <= -gx; cy_r <= -gy; ca_r <= za + HalfS;
          end else begin
            cx_r <= gx; cy_r <= gy; ca_r <= za;
          end
        end
      end else if (busy_r) begin
        if (cnt_r == CntW'(CordicSteps)) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          cx_r  <= cx_nxt;
          cy_r  <= cy_nxt;
          ca_r  <= ca_nxt;
        end
      end
      // Write back the finished pass (taken in the cycle busy falls).
      if (busy_r && cnt_r == CntW'(CordicSteps) && !cmd.start) begin
        case (op_r)
          OpRotPolar: begin vz_r <= cx_r; vy_r <= cy_r; end
          OpRotAzim:  begin vx_r <= cx_r; vy_r <= cy_r; end
          OpRotAxis: begin
            case (act_r)
              ActRotX: begin vy_r <= cx_r; vz_r <= cy_r; end
              ActRotY: begin vz_r <= cx_r; vx_r <= cy_r; end
              default: begin vx_r <= cx_r; vy_r <= cy_r; end
            endcase
          end
          OpVecAzim: begin
            vrad_r <= gx;
            az_r   <= 16'(ca_r) + Half;
          end
          OpVecPolar: zen_r <= Half - 16'(th_c);
          default: ;
        endcase
      end
      // Zero-length vectoring gives angle zero and no magnitude.
      if (cmd.start && ga == 0 && gb == 0) begin
        if (cmd.op == OpVecAzim) begin
          vrad_r <= '0;
          az_r   <= Half;
        end else if (cmd.op == OpVecPolar) begin
          zen_r <= Half;
        end
      end
    end
  end

  // Zenith stays within half a turn.
  a_zen: assert property (@(posedge clk) disable iff (!rst_n)
    zen_r <= Half) else $error("zenith out of range");
  // Counter never passes the step count.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(CordicSteps)) else $error("counter overrun");
  // Busy falls only after the last step.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) && !$past(cmd.start) |-> $past(cnt_r) == CntW'(CordicSteps))
    else $error("early finish");

endmodule

// File: hw/rtl/spherical_direction_rotator.sv
`timescale 1ns / 1ps
// Spherical direction rotator.
// Holds one direction as zenith and azimuth, in turn units of 2^-16 turn.
// Input channel in_*: action (set, rotate about x, y or z), polar_in and
// azim_in for a set, turn_angle for a rotate. A request is taken when
// in_valid and in_ready are both high at a rising edge of clk.
// Output channel out_*: zenith_out and azimuth_out, the stored direction
// after each request; one result per request.
// A set request runs no CORDIC pass. A rotate request runs five CORDIC
// passes (polar rotation, azimuth rotation, axis rotation, two vectoring
// passes) on one shared iteration unit; a vectoring pass on a zero-length
// vector skips its iterations.
// One request is in flight at a time.
// Reset (rst_n low, synchronous) clears the direction to zero and empties
// the output register. If the receiver stalls, the result stays in the
// output register and the block finishes the next request only up to its
// result, then waits for the register to empty.
module spherical_direction_rotator
  import sdr_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input logic       clk,
  input logic       rst_n,
  sdr_in_if.sink    in_ch,
  sdr_out_if.source out_ch
);

  sdr_cmd_t  cmd;
  sdr_stat_t stat;
  logic      in_ready;
  logic      out_valid;
  logic      in_fire;
  logic [15:0] zen, az;
  logic [15:0] zen_out_r, az_out_r;
  logic      load_out;

  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.zenith_out  = zen_out_r;
  assign out_ch.azimuth_out = az_out_r;

  sdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .load_out  (load_out),
    .cmd       (cmd),
    .stat      (stat)
  );

  sdr_dp #(.CordicSteps(CORDIC_STEPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_fire   (in_fire),
    .in_action (in_ch.action),
    .in_polar  (in_ch.polar_in),
    .in_azim   (in_ch.azim_in),
    .in_turn   (in_ch.turn_angle),
    .zenith    (zen),
    .azimuth   (az)
  );

  // Output register, loaded when a result is produced.
  always_ff @(posedge clk) begin
    if (load_out) begin
      zen_out_r <= zen;
      az_out_r  <= az;
    end
  end

endmodule
